/* sv/lrde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrde_pkg;

  localparam int CMD_W     = 3;
  localparam int OPERAND_W = 32;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int RESULT_W  = 32;
  localparam int WEIGHT_W  = 8;
  localparam int HALF_W    = 16;
  localparam int S_TDATA_W = 48;

  localparam logic [OPERAND_W-1:0] LCG_MUL    = 32'h41C6_4E6D;
  localparam logic [OPERAND_W-1:0] LCG_ADD    = 32'h0000_6073;
  localparam logic [OPERAND_W-1:0] PICK_RANGE = 32'd100;
  localparam logic [OPERAND_W-1:0] BOUND_MIN  = 32'd2;

  // one remainder bit per step
  localparam int DIV_STEPS = OPERAND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEED   = 3'd0,
    CMD_DRAW32 = 3'd1,
    CMD_DRAW16 = 3'd2,
    CMD_BND32  = 3'd3,
    CMD_BND16  = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_PICK   = 3'd6
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_seed;
    logic write_weight;
    logic mul;
    logic adv;
    logic div_step;
    logic walk_step;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic bound_small;
    logic count_zero;
    logic div_done;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/lrde_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrde_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire lrde_pkg::sts_t sts,
  output lrde_pkg::ctl_t     ctl
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_ADV    = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_WALK   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.cmd)
          lrde_pkg::CMD_SEED: begin
            ctl.load_seed = 1'b1;
            state_next    = ST_IDLE;
          end
          lrde_pkg::CMD_WRITE: begin
            ctl.write_weight = 1'b1;
            state_next       = ST_IDLE;
          end
          lrde_pkg::CMD_DRAW32, lrde_pkg::CMD_DRAW16: begin
            state_next = ST_MUL;
          end
          lrde_pkg::CMD_BND32, lrde_pkg::CMD_BND16: begin
            state_next = sts.bound_small ? ST_DONE : ST_MUL;
          end
          lrde_pkg::CMD_PICK: begin
            state_next = sts.count_zero ? ST_DONE : ST_MUL;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        // seed update and divider load share this cycle
        ctl.adv = 1'b1;
        if (sts.cmd == lrde_pkg::CMD_DRAW32 || sts.cmd == lrde_pkg::CMD_DRAW16) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = (sts.cmd == lrde_pkg::CMD_PICK) ? ST_WALK : ST_DONE;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      ST_WALK: begin
        ctl.walk_step = 1'b1;
        if (sts.walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lrde_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrde_dp #(
  parameter int WEIGHT_SLOTS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [lrde_pkg::S_TDATA_W-1:0]     s_tdata,
  input  wire logic [lrde_pkg::CMD_W-1:0]         s_tuser,
  input  wire lrde_pkg::ctl_t                     ctl,
  output lrde_pkg::sts_t                          sts,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [lrde_pkg::RESULT_W-1:0]           m_tdata
);

  localparam int OW = lrde_pkg::OPERAND_W;
  localparam int CW = lrde_pkg::COUNT_W;
  localparam int SLOT_REACH = 2 ** lrde_pkg::SLOT_W;
  // slots past the slot field's reach are never written and stay zero, so they
  // cannot change a running sum; only the reachable ones are stored
  localparam int TABLE_DEPTH = (WEIGHT_SLOTS < SLOT_REACH) ? WEIGHT_SLOTS : SLOT_REACH;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SUM_W = lrde_pkg::WEIGHT_W + $clog2(TABLE_DEPTH + 1);

  lrde_pkg::cmd_t                   cmd_q;
  logic [OW-1:0]                    operand_q;
  logic [lrde_pkg::SLOT_W-1:0]      slot_q;
  logic [CW-1:0]                    count_q;

  logic [OW-1:0]                    seed;
  logic [OW-1:0]                    prod;
  logic [OW-1:0]                    adv_val;

  logic [OW-1:0]                    rem;
  logic [OW-1:0]                    dvd;
  logic [OW-1:0]                    dvs;
  logic [lrde_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [OW:0]                      rem_sh;
  logic [OW:0]                      rem_diff;

  logic [lrde_pkg::WEIGHT_W-1:0]    wtab [TABLE_DEPTH];
  logic [CW-1:0]                    walk_i;
  logic [CW-1:0]                    walk_n;
  logic [SUM_W-1:0]                 sum;
  logic [SUM_W-1:0]                 sum_new;
  logic [CW-1:0]                    pick_idx;
  logic                             walk_hit;
  logic                             walk_last;

  logic                             half_draw;
  logic [OW-1:0]                    res_val;

  // capture the request
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q     <= lrde_pkg::cmd_t'(s_tuser);
      operand_q <= s_tdata[OW-1:0];
      slot_q    <= s_tdata[OW +: lrde_pkg::SLOT_W];
      count_q   <= s_tdata[OW + lrde_pkg::SLOT_W +: CW];
    end
  end

  assign half_draw = (cmd_q == lrde_pkg::CMD_DRAW16) || (cmd_q == lrde_pkg::CMD_BND16) ||
                     (cmd_q == lrde_pkg::CMD_PICK);

  // LCG: multiply, register, then add
  assign adv_val = prod + lrde_pkg::LCG_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (ctl.load_seed) begin
      seed <= operand_q;
    end else if (ctl.adv) begin
      seed <= adv_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= seed * lrde_pkg::LCG_MUL;
    end
  end

  // restoring divider, remainder only
  assign rem_sh   = {rem, dvd[OW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.adv) begin
      div_cnt <= lrde_pkg::DIV_CNT_W'(lrde_pkg::DIV_STEPS);
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem <= '0;
      dvd <= half_draw ? {{(OW - lrde_pkg::HALF_W){1'b0}}, adv_val[OW-1 -: lrde_pkg::HALF_W]}
                       : adv_val;
      dvs <= (cmd_q == lrde_pkg::CMD_PICK) ? lrde_pkg::PICK_RANGE : operand_q;
    end else if (ctl.div_step) begin
      rem <= rem_diff[OW] ? rem_sh[OW-1:0] : rem_diff[OW-1:0];
      dvd <= {dvd[OW-2:0], 1'b0};
    end
  end

  // weight table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        wtab[k] <= '0;
      end
    end else if (ctl.write_weight && (32'(slot_q) < TABLE_DEPTH)) begin
      wtab[slot_q[IDX_W-1:0]] <= operand_q[lrde_pkg::WEIGHT_W-1:0];
    end
  end

  // weighted walk, one slot per cycle; remainder holds the draw mod 100
  assign walk_n    = (32'(count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : count_q;
  assign sum_new   = sum + SUM_W'(wtab[walk_i[IDX_W-1:0]]);
  assign walk_hit  = (OW'(sum_new) > rem);
  assign walk_last = ((walk_i + 1'b1) == walk_n);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      walk_i   <= '0;
      sum      <= '0;
      pick_idx <= '0;
    end else if (ctl.walk_step) begin
      sum <= sum_new;
      if (walk_hit) begin
        pick_idx <= walk_i;
      end
      walk_i <= walk_i + 1'b1;
    end
  end

  // result select
  always_comb begin
    unique case (cmd_q)
      lrde_pkg::CMD_DRAW32: res_val = seed;
      lrde_pkg::CMD_DRAW16: res_val = {{(OW - lrde_pkg::HALF_W){1'b0}},
                                       seed[OW-1 -: lrde_pkg::HALF_W]};
      lrde_pkg::CMD_BND32, lrde_pkg::CMD_BND16: begin
        res_val = (operand_q < lrde_pkg::BOUND_MIN) ? '0 : rem;
      end
      lrde_pkg::CMD_PICK: res_val = (count_q == '0) ? '0 : OW'(pick_idx);
      default:            res_val = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= res_val;
    end
  end

  assign sts.cmd         = cmd_q;
  assign sts.bound_small = (operand_q < lrde_pkg::BOUND_MIN);
  assign sts.count_zero  = (count_q == '0);
  assign sts.div_done    = (div_cnt == '0);
  assign sts.walk_end    = walk_hit || walk_last;
  assign sts.out_free    = !m_tvalid || m_tready;

endmodule

`default_nettype wire

/* sv/lcg_random_draw_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// LCG draw engine: keeps a 32-bit seed (seed = seed * 0x41C64E6D + 0x6073) and a
// table of 8-bit weights cleared at reset. One request is worked at a time;
// s_tready is high only between requests, and a finished result sits in the
// output register so the next request can be taken while it waits. Seed load
// and weight write return nothing. Draw32/draw16 do the 32x32 multiply into
// a register, then the add into the seed. Bounded draws then run the
// bit-serial remainder unit (one bit per cycle); a bound below 2 returns 0
// and leaves the seed as it is. Weighted pick runs the same remainder unit
// by 100, then walks the weights one slot per cycle; count 0 returns 0.

module lcg_random_draw_engine #(
  parameter int WEIGHT_SLOTS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [31:0] operand, [35:32] slot, [40:36] count, [47:41] zero
  input  wire logic [lrde_pkg::S_TDATA_W-1:0]  s_tdata,
  // [2:0] cmd
  input  wire logic [lrde_pkg::CMD_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] result
  output logic [lrde_pkg::RESULT_W-1:0]        m_tdata
);

  lrde_pkg::ctl_t ctl;
  lrde_pkg::sts_t sts;

  lrde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lrde_dp #(
    .WEIGHT_SLOTS (WEIGHT_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .ctl      (ctl),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending one");

  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> m_tvalid)
    else $error("loaded result not presented");

  // no arithmetic in flight while a new request can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!ctl.div_step && !ctl.walk_step && !ctl.mul && !ctl.adv))
    else $error("datapath busy while taking a request");

endmodule

`default_nettype wire
